// File: src/hemc_pkg.sv
// ----------------------------------------------------------------------------
// hemc_pkg
// Shared constants, register codes and helpers for the elevation collapse.
// ----------------------------------------------------------------------------
package hemc_pkg;

    // default geometry and datapath sizes
    localparam int DEF_MAX_AZIMUTH    = 128;
    localparam int DEF_MAX_RANGE      = 128;
    localparam int DEF_MAX_ELEVATION  = 32;
    localparam int DEF_INTENSITY_BITS = 32;

    // fixed field widths
    localparam int SLOT_W      = 5;
    localparam int SINE_W      = 16;
    localparam int INTEN_IN_W  = 32;
    localparam int DOPPLER_W   = 16;
    localparam int HEIGHT_W    = 23;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 48;

    // action codes carried in s_tuser
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AZIMUTH_COUNT   = 3'd0,
        CFG_RANGE_COUNT     = 3'd1,
        CFG_ELEVATION_COUNT = 3'd2,
        CFG_HEIGHT_MIN      = 3'd3,
        CFG_HEIGHT_MAX      = 3'd4
    } cfg_index_t;

    // register reset values
    localparam logic [7:0]          RST_AZIMUTH_COUNT   = 8'd128;
    localparam logic [7:0]          RST_RANGE_COUNT     = 8'd128;
    localparam logic [5:0]          RST_ELEVATION_COUNT = 6'd32;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT_MIN      = 23'h400000;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT_MAX      = 23'h3FFFFF;

    // position flags of one sample within the image
    typedef struct packed {
        logic first_el;   // elevation 0: cell entry is overwritten
        logic last_el;    // last elevation: cell is emitted
        logic img_last;   // last azimuth and range cell
    } scan_flags_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic int clamp_count(input logic [7:0] v, input int maxv);
        int r;
        r = int'(v);
        if (r == 0) begin
            r = 1;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

// File: src/hemc_ram.sv
// ----------------------------------------------------------------------------
// hemc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hemc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/hemc_scan.sv
// ----------------------------------------------------------------------------
// hemc_scan
// Elevation, azimuth and range counters and the cell address of each sample.
// ----------------------------------------------------------------------------
module hemc_scan
    import hemc_pkg::*;
#(
    parameter int MAX_AZIMUTH   = DEF_MAX_AZIMUTH,
    parameter int MAX_RANGE     = DEF_MAX_RANGE,
    parameter int MAX_ELEVATION = DEF_MAX_ELEVATION,
    localparam int AZ_W   = (MAX_AZIMUTH > 1) ? $clog2(MAX_AZIMUTH) : 1,
    localparam int RG_W   = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1,
    localparam int EL_W   = (MAX_ELEVATION > 1) ? $clog2(MAX_ELEVATION) : 1,
    localparam int CELLS  = MAX_AZIMUTH * MAX_RANGE,
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [7:0]        azimuth_count,
    input  logic [7:0]        range_count,
    input  logic [5:0]        elevation_count,
    output logic [EL_W-1:0]   el_idx,
    output logic [RG_W-1:0]   rg_idx,
    output logic [CELL_W-1:0] cell_addr,
    output scan_flags_t       flags
);

    logic [AZ_W-1:0] az_reg, az_next;
    logic [RG_W-1:0] rg_reg, rg_next;
    logic [EL_W-1:0] el_reg, el_next;

    logic [AZ_W:0] n_az, az_inc;
    logic [RG_W:0] n_rg, rg_inc;
    logic [EL_W:0] n_el, el_inc;

    // effective counts
    assign n_az = (AZ_W+1)'(clamp_count(azimuth_count, MAX_AZIMUTH));
    assign n_rg = (RG_W+1)'(clamp_count(range_count, MAX_RANGE));
    assign n_el = (EL_W+1)'(clamp_count({2'b00, elevation_count}, MAX_ELEVATION));

    assign az_inc = {1'b0, az_reg} + 1'b1;
    assign rg_inc = {1'b0, rg_reg} + 1'b1;
    assign el_inc = {1'b0, el_reg} + 1'b1;

    // position of the current sample
    assign el_idx    = el_reg;
    assign rg_idx    = rg_reg;
    assign cell_addr = CELL_W'(int'(az_reg) * MAX_RANGE + int'(rg_reg));

    assign flags.first_el = (el_reg == '0);
    assign flags.last_el  = (el_inc >= n_el);
    assign flags.img_last = (az_inc >= n_az) && (rg_inc >= n_rg);

    // range innermost, elevation outermost; wrap at or beyond the count
    always_comb begin
        rg_next = rg_reg;
        az_next = az_reg;
        el_next = el_reg;
        if (rg_inc >= n_rg) begin
            rg_next = '0;
            if (az_inc >= n_az) begin
                az_next = '0;
                if (el_inc >= n_el) begin
                    el_next = '0;
                end else begin
                    el_next = el_inc[EL_W-1:0];
                end
            end else begin
                az_next = az_inc[AZ_W-1:0];
            end
        end else begin
            rg_next = rg_inc[RG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_reg <= '0;
            rg_reg <= '0;
            el_reg <= '0;
        end else if (advance) begin
            az_reg <= az_next;
            rg_reg <= rg_next;
            el_reg <= el_next;
        end
    end

endmodule

// File: src/hemc_gate_update.sv
// ----------------------------------------------------------------------------
// hemc_gate_update
// Height gate and running maximum for one sample against its cell entry.
// ----------------------------------------------------------------------------
module hemc_gate_update
    import hemc_pkg::*;
#(
    parameter int MAX_RANGE      = DEF_MAX_RANGE,
    parameter int INTENSITY_BITS = DEF_INTENSITY_BITS,
    localparam int RG_W  = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1,
    localparam int PROD_W = RG_W + 1 + SINE_W,
    localparam int CMP_W = (PROD_W > HEIGHT_W) ? PROD_W : HEIGHT_W
) (
    input  logic [RG_W-1:0]            rg_idx,
    input  logic signed [SINE_W-1:0]   sine,
    input  logic signed [HEIGHT_W-1:0] height_min,
    input  logic signed [HEIGHT_W-1:0] height_max,
    input  logic [INTENSITY_BITS-1:0]  inten,
    input  logic [DOPPLER_W-1:0]       dop,
    input  logic                       first_el,
    input  logic                       best_found,
    input  logic [INTENSITY_BITS-1:0]  best_inten,
    input  logic [DOPPLER_W-1:0]       best_dop,
    output logic                       new_found,
    output logic [INTENSITY_BITS-1:0]  new_inten,
    output logic [DOPPLER_W-1:0]       new_dop
);

    logic signed [PROD_W-1:0] height;
    logic signed [CMP_W-1:0]  height_ext, lo_ext, hi_ext;
    logic                     counts;

    // height in Q9.15: range bin times Q1.15 sine
    assign height     = $signed({1'b0, rg_idx}) * sine;
    assign height_ext = CMP_W'(height);
    assign lo_ext     = CMP_W'(height_min);
    assign hi_ext     = CMP_W'(height_max);
    assign counts     = (height_ext >= lo_ext) && (height_ext <= hi_ext);

    // first elevation starts the cell; later in-window ones win over none or less
    always_comb begin
        new_found = best_found;
        new_inten = best_inten;
        new_dop   = best_dop;
        if (first_el) begin
            new_found = counts;
            new_inten = counts ? inten : '0;
            new_dop   = counts ? dop : '0;
        end else if (counts && (!best_found || (inten > best_inten))) begin
            new_found = 1'b1;
            new_inten = inten;
            new_dop   = dop;
        end
    end

endmodule

// File: src/heatmap_elevation_max_collapse_top.sv
// ----------------------------------------------------------------------------
// heatmap_elevation_max_collapse_top
// Max intensity projection of a radar heatmap over elevation, height gated.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: s_tuser selects the action. A load writes one sine table
//   entry; a sample carries intensity and doppler in image order (elevation
//   outer, azimuth, range inner). Cell indices are counted internally.
//   m_ channel: one request per cell on the last elevation; m_tlast marks
//   the last cell of the image, m_tuser flags a cell with no sample in the
//   height window (data then zero).
//   cfg_ channel: register writes, always ready; write only while idle.
// Timing:
//   One item per cycle sustained while the output is not stalled. A sample
//   is held in the update stage, where the cell memory read is combined with
//   the gate and written back; a one-deep bypass covers back-to-back hits on
//   the same cell. The update stage passes the result to the output register.
// Reset: counters restart at the first cell, registers take their defaults;
//   the sine table and the cell memory hold nothing until written.
// Stall: a waiting result holds; samples that emit nothing keep flowing
//   until the next emitting sample reaches the update stage.
// ----------------------------------------------------------------------------
module heatmap_elevation_max_collapse_top
    import hemc_pkg::*;
#(
    parameter int MAX_AZIMUTH    = DEF_MAX_AZIMUTH,
    parameter int MAX_RANGE      = DEF_MAX_RANGE,
    parameter int MAX_ELEVATION  = DEF_MAX_ELEVATION,
    parameter int INTENSITY_BITS = DEF_INTENSITY_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // fields: table_slot[4:0], sine_value[20:5], intensity[52:21], doppler[68:53]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // fields: action[0]
    input  logic [0:0]             s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // fields: max_intensity[31:0], doppler_at_max[47:32]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // fields: none_in_window[0]
    output logic [0:0]             m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int RG_W   = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;
    localparam int EL_W   = (MAX_ELEVATION > 1) ? $clog2(MAX_ELEVATION) : 1;
    localparam int CELLS  = MAX_AZIMUTH * MAX_RANGE;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int WORD_W = INTENSITY_BITS + DOPPLER_W + 1;

    // configuration registers
    logic [7:0]          az_count_reg;
    logic [7:0]          rg_count_reg;
    logic [5:0]          el_count_reg;
    logic [HEIGHT_W-1:0] hmin_reg;
    logic [HEIGHT_W-1:0] hmax_reg;

    // input fields
    logic [SLOT_W-1:0]         in_slot;
    logic [SINE_W-1:0]         in_sine;
    logic [INTEN_IN_W-1:0]     in_inten;
    logic [DOPPLER_W-1:0]      in_dop;
    logic                      load_acc, sample_acc;

    // scan position
    logic [EL_W-1:0]   scan_el;
    logic [RG_W-1:0]   scan_rg;
    logic [CELL_W-1:0] scan_cell;
    scan_flags_t       scan_flags;

    // update stage
    logic                      p1_valid_reg;
    logic [CELL_W-1:0]         p1_cell_reg;
    logic [RG_W-1:0]           p1_rg_reg;
    logic [INTENSITY_BITS-1:0] p1_inten_reg;
    logic [DOPPLER_W-1:0]      p1_dop_reg;
    scan_flags_t               p1_flags_reg;
    logic                      fwd_hit_reg;
    logic [WORD_W-1:0]         fwd_word_reg;
    logic                      p1_adv, out_free;

    logic [SINE_W-1:0]         sine_rdata;
    logic [WORD_W-1:0]         cell_rdata, best_word, new_word;
    logic                      new_found;
    logic [INTENSITY_BITS-1:0] new_inten;
    logic [DOPPLER_W-1:0]      new_dop;

    // output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_none_reg;
    logic                 m_last_reg;

    // unpack the input request
    assign in_slot  = s_tdata[4:0];
    assign in_sine  = s_tdata[20:5];
    assign in_inten = s_tdata[52:21];
    assign in_dop   = s_tdata[68:53];

    assign load_acc   = s_tvalid && s_tready && (s_tuser[0] == ACT_LOAD);
    assign sample_acc = s_tvalid && s_tready && (s_tuser[0] == ACT_SAMPLE);

    // update stage moves when it emits nothing or the output register frees up
    assign out_free = !m_valid_reg || m_tready;
    assign p1_adv   = p1_valid_reg && (!p1_flags_reg.last_el || out_free);
    assign s_tready = !p1_valid_reg || p1_adv;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_count_reg <= RST_AZIMUTH_COUNT;
            rg_count_reg <= RST_RANGE_COUNT;
            el_count_reg <= RST_ELEVATION_COUNT;
            hmin_reg     <= RST_HEIGHT_MIN;
            hmax_reg     <= RST_HEIGHT_MAX;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_AZIMUTH_COUNT:   az_count_reg <= cfg_data[7:0];
                CFG_RANGE_COUNT:     rg_count_reg <= cfg_data[7:0];
                CFG_ELEVATION_COUNT: el_count_reg <= cfg_data[5:0];
                CFG_HEIGHT_MIN:      hmin_reg     <= cfg_data[HEIGHT_W-1:0];
                CFG_HEIGHT_MAX:      hmax_reg     <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // position counters
    hemc_scan #(
        .MAX_AZIMUTH   (MAX_AZIMUTH),
        .MAX_RANGE     (MAX_RANGE),
        .MAX_ELEVATION (MAX_ELEVATION)
    ) u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (sample_acc),
        .azimuth_count   (az_count_reg),
        .range_count     (rg_count_reg),
        .elevation_count (el_count_reg),
        .el_idx          (scan_el),
        .rg_idx          (scan_rg),
        .cell_addr       (scan_cell),
        .flags           (scan_flags)
    );

    // sine table: loaded by load requests, read for each sample
    hemc_ram #(
        .WIDTH (SINE_W),
        .DEPTH (MAX_ELEVATION)
    ) u_sine_ram (
        .aclk  (aclk),
        .we    (load_acc && (int'(in_slot) < MAX_ELEVATION)),
        .waddr (EL_W'(in_slot)),
        .wdata (in_sine),
        .re    (sample_acc),
        .raddr (scan_el),
        .rdata (sine_rdata)
    );

    // per-cell running best: {found, doppler, intensity}
    hemc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (p1_adv),
        .waddr (p1_cell_reg),
        .wdata (new_word),
        .re    (sample_acc),
        .raddr (scan_cell),
        .rdata (cell_rdata)
    );

    // capture a sample into the update stage; bypass a same-cell write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= sample_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            p1_cell_reg  <= scan_cell;
            p1_rg_reg    <= scan_rg;
            p1_inten_reg <= INTENSITY_BITS'(in_inten);
            p1_dop_reg   <= in_dop;
            p1_flags_reg <= scan_flags;
            fwd_hit_reg  <= p1_adv && (p1_cell_reg == scan_cell);
        end
        if (p1_adv) begin
            fwd_word_reg <= new_word;
        end
    end

    assign best_word = fwd_hit_reg ? fwd_word_reg : cell_rdata;

    hemc_gate_update #(
        .MAX_RANGE      (MAX_RANGE),
        .INTENSITY_BITS (INTENSITY_BITS)
    ) u_update (
        .rg_idx     (p1_rg_reg),
        .sine       ($signed(sine_rdata)),
        .height_min ($signed(hmin_reg)),
        .height_max ($signed(hmax_reg)),
        .inten      (p1_inten_reg),
        .dop        (p1_dop_reg),
        .first_el   (p1_flags_reg.first_el),
        .best_found (best_word[WORD_W-1]),
        .best_inten (best_word[INTENSITY_BITS-1:0]),
        .best_dop   (best_word[WORD_W-2:INTENSITY_BITS]),
        .new_found  (new_found),
        .new_inten  (new_inten),
        .new_dop    (new_dop)
    );

    assign new_word = {new_found, new_dop, new_inten};

    // output register, loaded on the last elevation of a cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv && p1_flags_reg.last_el) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && p1_flags_reg.last_el) begin
            m_data_reg <= new_found ? {new_dop, INTEN_IN_W'(new_inten)} : '0;
            m_none_reg <= !new_found;
            m_last_reg <= p1_flags_reg.img_last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_none_reg;
    assign m_tlast    = m_last_reg;

endmodule

// File: src/hemc_checker.sv
// ----------------------------------------------------------------------------
// hemc_checker
// Port-level checks of the elevation collapse, bound to the top level.
// ----------------------------------------------------------------------------
module hemc_checker
    import hemc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser,
    input logic                 m_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // a cell with nothing in the window reports zero data
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0))
        else $error("empty cell with nonzero data");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind heatmap_elevation_max_collapse_top hemc_checker u_hemc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
